// ----- rtl/core/mvn_pkg.sv -----
// ----------------------------------------------------------------------------
// mvn_pkg
// shared types and result codes of the masked vector normalizer
// ----------------------------------------------------------------------------
package mvn_pkg;

    typedef enum logic [1:0] {
        KIND_NORM = 2'd0,
        KIND_MASK = 2'd1,
        KIND_ZERO = 2'd2
    } kind_t;

    // control that travels with each transaction down the pipeline
    typedef struct packed {
        logic  valid;
        kind_t kind;
    } ctl_t;

endpackage

// ----- rtl/core/mvn_front.sv -----
// ----------------------------------------------------------------------------
// mvn_front
// magnitudes, squares, squared length and root seeds, four register stages
// ----------------------------------------------------------------------------
module mvn_front
    import mvn_pkg::*;
#(
    parameter int COMP_WIDTH    = 16,
    parameter int OUT_FRAC_BITS = 14
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  logic [7:0]                                     mask_limit,
    input  logic [7:0]                                     mask_code,
    input  logic signed [COMP_WIDTH-1:0]                   comp_x,
    input  logic signed [COMP_WIDTH-1:0]                   comp_y,
    input  logic signed [COMP_WIDTH-1:0]                   comp_z,
    output ctl_t                                           ctl_out,
    output logic [2*COMP_WIDTH-1:0]                        len_out,
    output logic signed [2*COMP_WIDTH+2*OUT_FRAC_BITS+3:0] d_out [3],
    output logic signed [2*COMP_WIDTH+2*OUT_FRAC_BITS+3:0] p_out,
    output logic                                           neg_out [3]
);

    localparam int DW = 2*COMP_WIDTH + 2*OUT_FRAC_BITS + 4;
    localparam int LW = 2*COMP_WIDTH;

    logic                  va_reg, vb_reg, vc_reg, vd_reg;
    logic                  masked_a_reg, masked_b_reg, masked_c_reg;
    kind_t                 kind_d_reg, kind_d_next;
    logic [COMP_WIDTH-1:0] mag_a_reg [3];
    logic                  neg_a_reg [3];
    logic                  neg_b_reg [3];
    logic                  neg_c_reg [3];
    logic                  neg_d_reg [3];
    logic [LW-1:0]         sq_b_reg [3];
    logic [LW-1:0]         sq_c_reg [3];
    logic [LW-1:0]         len_c_reg;
    logic [LW-1:0]         len_d_reg;
    logic signed [DW-1:0]  d_d_reg [3];
    logic signed [DW-1:0]  p_d_reg;
    logic [COMP_WIDTH-1:0] comp_raw [3];
    logic signed [DW-1:0]  len_ext;

    assign comp_raw[0] = comp_x;
    assign comp_raw[1] = comp_y;
    assign comp_raw[2] = comp_z;
    assign len_ext     = $signed({{(DW-LW){1'b0}}, len_c_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_comb
    begin
        if (masked_c_reg)
            kind_d_next = KIND_MASK;
        else if (len_c_reg == '0)
            kind_d_next = KIND_ZERO;
        else
            kind_d_next = KIND_NORM;
    end

    always_ff @(posedge clk)
    begin
        masked_a_reg <= (mask_code <= mask_limit);
        masked_b_reg <= masked_a_reg;
        masked_c_reg <= masked_b_reg;
        kind_d_reg   <= kind_d_next;
        for (int i = 0; i < 3; i++)
        begin
            // the most negative code maps to 2^(w-1), still fits unsigned
            neg_a_reg[i] <= comp_raw[i][COMP_WIDTH-1];
            mag_a_reg[i] <= comp_raw[i][COMP_WIDTH-1] ? (~comp_raw[i] + 1'b1)
                                                       : comp_raw[i];
            neg_b_reg[i] <= neg_a_reg[i];
            sq_b_reg[i]  <= LW'(mag_a_reg[i]) * LW'(mag_a_reg[i]);
            neg_c_reg[i] <= neg_b_reg[i];
            sq_c_reg[i]  <= sq_b_reg[i];
            neg_d_reg[i] <= neg_c_reg[i];
            // remainder seed: m^2 * 4^(f+1) - len2 (odd term starts at -1)
            d_d_reg[i]   <= ($signed({{(DW-LW){1'b0}}, sq_c_reg[i]})
                             <<< (2*OUT_FRAC_BITS + 2)) - len_ext;
        end
        len_c_reg <= sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];
        len_d_reg <= len_c_reg;
        p_d_reg   <= -len_ext;
    end

    assign ctl_out.valid = vd_reg;
    assign ctl_out.kind  = kind_d_reg;
    assign len_out       = len_d_reg;
    assign p_out         = p_d_reg;
    assign d_out         = d_d_reg;
    assign neg_out       = neg_d_reg;

endmodule

// ----- rtl/core/mvn_root_step.sv -----
// ----------------------------------------------------------------------------
// mvn_root_step
// one registered bit step of the rounded quotient search for one component
// ----------------------------------------------------------------------------
module mvn_root_step
    import mvn_pkg::*;
#(
    parameter int COMP_WIDTH    = 16,
    parameter int OUT_FRAC_BITS = 14,
    parameter int BIT           = 0
)
(
    input  logic                                           clk,
    input  logic [2*COMP_WIDTH-1:0]                        len_in,
    input  logic signed [2*COMP_WIDTH+2*OUT_FRAC_BITS+3:0] d_in,
    input  logic signed [2*COMP_WIDTH+2*OUT_FRAC_BITS+3:0] p_in,
    input  logic [OUT_FRAC_BITS:0]                         q_in,
    input  logic                                           neg_in,
    output logic [2*COMP_WIDTH-1:0]                        len_out,
    output logic signed [2*COMP_WIDTH+2*OUT_FRAC_BITS+3:0] d_out,
    output logic signed [2*COMP_WIDTH+2*OUT_FRAC_BITS+3:0] p_out,
    output logic [OUT_FRAC_BITS:0]                         q_out,
    output logic                                           neg_out
);

    localparam int DW = 2*COMP_WIDTH + 2*OUT_FRAC_BITS + 4;
    localparam int LW = 2*COMP_WIDTH;
    localparam int QW = OUT_FRAC_BITS + 1;

    logic signed [DW-1:0] len_ext;
    logic signed [DW-1:0] trial;
    logic                 take;
    logic [LW-1:0]        len_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] p_reg;
    logic [QW-1:0]        q_reg;
    logic                 neg_reg;

    // d holds m^2*4^(f+1) - u^2*len2 and p holds u*len2, u = 2q-1
    assign len_ext = $signed({{(DW-LW){1'b0}}, len_in});
    assign trial   = d_in - ((p_in <<< (BIT + 2)) + (len_ext <<< (2*BIT + 2)));
    // once q reaches one no lower bit may be added
    assign take    = !trial[DW-1] && ((BIT == OUT_FRAC_BITS) || !q_in[OUT_FRAC_BITS]);

    always_ff @(posedge clk)
    begin
        len_reg <= len_in;
        neg_reg <= neg_in;
        d_reg   <= take ? trial : d_in;
        p_reg   <= take ? (p_in + (len_ext <<< (BIT + 1))) : p_in;
        q_reg   <= take ? (q_in | (QW'(1) << BIT)) : q_in;
    end

    assign len_out = len_reg;
    assign d_out   = d_reg;
    assign p_out   = p_reg;
    assign q_out   = q_reg;
    assign neg_out = neg_reg;

endmodule

// ----- rtl/core/masked_vector3_normalizer_unit.sv -----
// ----------------------------------------------------------------------------
// masked_vector3_normalizer_unit
// masked three-component vector normalizer with signed q1.f results
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle, busy stays low
// cost per cycle is set by one bit step of the quotient search per stage
// reset: asynchronous, clears valid bits and sets mask_limit to 1
// done is a one-cycle strobe; the receiver cannot stall
module masked_vector3_normalizer_unit
    import mvn_pkg::*;
#(
    parameter int COMP_WIDTH    = 16,
    parameter int OUT_FRAC_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          limit_we,
    input  logic [7:0]                    limit_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    mask_code,
    input  logic signed [COMP_WIDTH-1:0]  comp_x,
    input  logic signed [COMP_WIDTH-1:0]  comp_y,
    input  logic signed [COMP_WIDTH-1:0]  comp_z,
    output logic                          done,
    output logic signed [OUT_FRAC_BITS+1:0] unit_x,
    output logic signed [OUT_FRAC_BITS+1:0] unit_y,
    output logic signed [OUT_FRAC_BITS+1:0] unit_z,
    output logic [1:0]                    result_kind
);

    localparam int DW    = 2*COMP_WIDTH + 2*OUT_FRAC_BITS + 4;
    localparam int LW    = 2*COMP_WIDTH;
    localparam int QW    = OUT_FRAC_BITS + 1;
    localparam int OW    = OUT_FRAC_BITS + 2;
    localparam int NS    = OUT_FRAC_BITS + 1;
    localparam int LAT   = OUT_FRAC_BITS + 6;

    logic [7:0]           mask_limit_reg;
    ctl_t                 ctl_c [NS+1];
    logic [LW-1:0]        len_c [3][NS+1];
    logic signed [DW-1:0] d_c   [3][NS+1];
    logic signed [DW-1:0] p_c   [3][NS+1];
    logic [QW-1:0]        q_c   [3][NS+1];
    logic                 neg_c [3][NS+1];
    logic signed [DW-1:0] d_front [3];
    logic signed [DW-1:0] p_front;
    logic                 neg_front [3];
    logic [LW-1:0]        len_front;
    logic                 done_reg;
    kind_t                kind_reg;
    logic [OW-1:0]        unit_reg [3];
    logic [OW-1:0]        unit_next [3];
    logic [OW-1:0]        mag_o [3];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_limit_reg <= 8'd1;
        else if (limit_we)
            mask_limit_reg <= limit_data;
    end

    mvn_front #(
        .COMP_WIDTH    (COMP_WIDTH),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .mask_limit (mask_limit_reg),
        .mask_code  (mask_code),
        .comp_x     (comp_x),
        .comp_y     (comp_y),
        .comp_z     (comp_z),
        .ctl_out    (ctl_c[0]),
        .len_out    (len_front),
        .d_out      (d_front),
        .p_out      (p_front),
        .neg_out    (neg_front)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_seed
        assign len_c[i][0] = len_front;
        assign d_c[i][0]   = d_front[i];
        assign p_c[i][0]   = p_front;
        assign q_c[i][0]   = '0;
        assign neg_c[i][0] = neg_front[i];
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_c[k+1] <= '0;
            else
                ctl_c[k+1] <= ctl_c[k];
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            mvn_root_step #(
                .COMP_WIDTH    (COMP_WIDTH),
                .OUT_FRAC_BITS (OUT_FRAC_BITS),
                .BIT           (OUT_FRAC_BITS - k)
            ) u_step (
                .clk     (clk),
                .len_in  (len_c[i][k]),
                .d_in    (d_c[i][k]),
                .p_in    (p_c[i][k]),
                .q_in    (q_c[i][k]),
                .neg_in  (neg_c[i][k]),
                .len_out (len_c[i][k+1]),
                .d_out   (d_c[i][k+1]),
                .p_out   (p_c[i][k+1]),
                .q_out   (q_c[i][k+1]),
                .neg_out (neg_c[i][k+1])
            );
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_o[i] = {1'b0, q_c[i][NS]};
            unit_next[i] = '0;
        end
        unique case (ctl_c[NS].kind)
            KIND_NORM:
            begin
                for (int i = 0; i < 3; i++)
                    unit_next[i] = neg_c[i][NS] ? (~mag_o[i] + 1'b1) : mag_o[i];
            end
            KIND_MASK:
                unit_next[0] = OW'(1) << OUT_FRAC_BITS;
            default:
            begin
                for (int i = 0; i < 3; i++)
                    unit_next[i] = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_c[NS].valid;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= ctl_c[NS].kind;
        unit_reg <= unit_next;
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign unit_x      = $signed(unit_reg[0]);
    assign unit_y      = $signed(unit_reg[1]);
    assign unit_z      = $signed(unit_reg[2]);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transaction did not complete at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    a_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == KIND_MASK) |->
        (unit_x == (OW'(1) << OUT_FRAC_BITS) && unit_y == '0 && unit_z == '0))
        else $error("masked result is not the default vector");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == KIND_ZERO) |->
        (unit_x == '0 && unit_y == '0 && unit_z == '0))
        else $error("zero-length result is not all zeros");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (unit_x <= $signed(OW'(1) << OUT_FRAC_BITS)
               && unit_x >= -$signed(OW'(1) << OUT_FRAC_BITS)))
        else $error("normalized component out of range");

endmodule

// ----- dv/masked_vector3_normalizer_unit_test.sv -----
// ----------------------------------------------------------------------------
// masked_vector3_normalizer_unit_test
// drives masked vectors through the normalizer with random start gaps, predicts
// each q1.14 unit vector with an exact bit-serial search and checks every
// transaction in order across several mask_limit settings
// ----------------------------------------------------------------------------
module masked_vector3_normalizer_unit_test
    import mvn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam int OW = FB + 2;
    localparam int LATENCY = FB + 6;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [7:0]          code;
        logic signed [CW-1:0] x, y, z;
        bit                  is_cfg;
        logic [7:0]          limit;
    } vec_item_t;

    typedef struct {
        logic signed [OW-1:0] ux, uy, uz;
        kind_t               kind;
    } unit_vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic limit_we = 1'b0;
    logic [7:0] limit_data = 8'd0;
    logic start = 1'b0;
    logic busy;
    logic [7:0] mask_code = 8'd0;
    logic signed [CW-1:0] comp_x = '0, comp_y = '0, comp_z = '0;
    logic done;
    logic signed [OW-1:0] unit_x, unit_y, unit_z;
    logic [1:0] result_kind;

    vec_item_t pending_q[$];
    unit_vec_t expected_q[$];
    // reset value of the limit
    logic [7:0] model_limit = 8'd1;
    int errors = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    bit stim_done = 0;

    masked_vector3_normalizer_unit #(.COMP_WIDTH(CW), .OUT_FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n), .limit_we(limit_we), .limit_data(limit_data),
        .start(start), .busy(busy), .mask_code(mask_code), .comp_x(comp_x),
        .comp_y(comp_y), .comp_z(comp_z), .done(done), .unit_x(unit_x),
        .unit_y(unit_y), .unit_z(unit_z), .result_kind(result_kind)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [CW-1:0] abs_comp(logic signed [CW-1:0] c);
        logic [CW:0] w;
        w = {c[CW-1], c};
        return c[CW-1] ? CW'(-w) : CW'(c);
    endfunction

    // largest q <= 2^F with (2q-1)^2 * len2 <= mag^2 * 2^(2F+2)
    function automatic logic signed [OW-1:0] unit_comp(logic signed [CW-1:0] c,
                                                       logic [63:0] len2);
        logic [63:0] mag, q, t, odd;
        logic [127:0] lhs, rhs;
        mag = 64'(abs_comp(c));
        q = 0;
        for (int b = FB; b >= 0; b--)
        begin
            t = q | (64'd1 << b);
            odd = 2 * t - 1;
            lhs = 128'(odd * odd) * 128'(len2);
            rhs = 128'(mag * mag) << (2 * FB + 2);
            if (t <= (64'd1 << FB) && lhs <= rhs)
                q = t;
        end
        return c[CW-1] ? OW'(-q) : OW'(q);
    endfunction

    function automatic unit_vec_t normalize(vec_item_t it, logic [7:0] lim);
        unit_vec_t r;
        logic [63:0] mx, my, mz, len2;
        r.ux = 0; r.uy = 0; r.uz = 0;
        if (it.code <= lim)
        begin
            r.ux = OW'(1 << FB);
            r.kind = KIND_MASK;
            return r;
        end
        mx = 64'(abs_comp(it.x));
        my = 64'(abs_comp(it.y));
        mz = 64'(abs_comp(it.z));
        len2 = mx * mx + my * my + mz * mz;
        if (len2 == 0)
        begin
            r.kind = KIND_ZERO;
            return r;
        end
        r.ux = unit_comp(it.x, len2);
        r.uy = unit_comp(it.y, len2);
        r.uz = unit_comp(it.z, len2);
        r.kind = KIND_NORM;
        return r;
    endfunction

    task automatic push_vec(logic [7:0] c, logic signed [CW-1:0] x, y, z);
        vec_item_t it;
        it.code = c; it.x = x; it.y = y; it.z = z; it.is_cfg = 0; it.limit = 0;
        pending_q.push_back(it);
    endtask

    task automatic push_limit(logic [7:0] v);
        vec_item_t it;
        it = '{default: 0};
        it.is_cfg = 1; it.limit = v;
        pending_q.push_back(it);
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return CW'($urandom_range(0, 6)) - 16'sd3;
            3: return 16'sd0;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // driver: config writes wait until the pipeline has drained
    always @(posedge clk)
    begin
        limit_we <= 1'b0;
        if (rst_n)
        begin
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0 && pending_q[0].is_cfg)
                begin
                    start <= 1'b0;
                    if (expected_q.size() == 0 && !(start && !busy))
                    begin
                        limit_we <= 1'b1;
                        limit_data <= pending_q[0].limit;
                        model_limit = pending_q[0].limit;
                        void'(pending_q.pop_front());
                        gap_left <= LATENCY;
                    end
                end
                else if (pending_q.size() > 0)
                begin
                    start <= 1'b1;
                    mask_code <= pending_q[0].code;
                    comp_x <= pending_q[0].x;
                    comp_y <= pending_q[0].y;
                    comp_z <= pending_q[0].z;
                    expected_q.push_back(normalize(pending_q[0], model_limit));
                    void'(pending_q.pop_front());
                    gap_left <= rand_gap();
                end
                else
                begin
                    start <= 1'b0;
                    stim_done = 1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                idle_cycles <= 0;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction kind=%0d", $time, result_kind);
                    errors++;
                end
                else
                begin
                    if (unit_x !== expected_q[0].ux || unit_y !== expected_q[0].uy ||
                        unit_z !== expected_q[0].uz || result_kind !== expected_q[0].kind)
                    begin
                        $display("%0t: expected (%0d,%0d,%0d) kind %0d, actual (%0d,%0d,%0d) kind %0d",
                                 $time, expected_q[0].ux, expected_q[0].uy,
                                 expected_q[0].uz, expected_q[0].kind,
                                 unit_x, unit_y, unit_z, result_kind);
                        errors++;
                    end
                    void'(expected_q.pop_front());
                end
            end
            else if (start && !busy)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] lim;
        push_vec(8'd0, 16'sd5, 16'sd5, 16'sd5);
        push_vec(8'd1, 16'sd5, 16'sd5, 16'sd5);
        push_vec(8'd2, 16'sd0, 16'sd0, 16'sd0);
        push_vec(8'd255, 16'sd3, 16'sd4, 16'sd0);
        push_vec(8'd255, -16'sd32768, -16'sd32768, -16'sd32768);
        push_vec(8'd255, 16'sd32767, 16'sd32767, 16'sd32767);
        push_vec(8'd255, -16'sd32768, 16'sd0, 16'sd0);
        push_vec(8'd255, 16'sd0, 16'sd32767, 16'sd0);
        push_vec(8'd255, 16'sd0, 16'sd0, -16'sd1);
        push_vec(8'd200, 16'sd1, -16'sd1, 16'sd1);
        push_vec(8'd128, -16'sd32768, 16'sd32767, 16'sd1);
        push_vec(8'd255, -16'sd1, -16'sd1, -16'sd1);
        push_limit(8'd0);
        push_vec(8'd0, 16'sd7, 16'sd0, 16'sd0);
        push_vec(8'd1, 16'sd0, 16'sd0, 16'sd0);
        push_vec(8'd1, 16'sd2, -16'sd2, 16'sd1);
        push_limit(8'd255);
        push_vec(8'd255, 16'sd3, 16'sd4, 16'sd5);
        push_vec(8'd0, 16'sd3, 16'sd4, 16'sd5);
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: lim = 8'd0;
                1: lim = 8'd1;
                2: lim = 8'd254;
                3: lim = 8'd255;
                default: lim = 8'($urandom);
            endcase
            push_limit(lim);
            for (int i = 0; i < 240; i++)
                push_vec(8'($urandom), rand_comp(), rand_comp(), rand_comp());
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_q.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
